[hdl/swmrm_pkg.sv]
// swmrm_pkg: shared constants and types for the sliding window median rate meter.
// Used by swmrm_cell, swmrm_divider and sliding_window_median_rate_meter_unit.
// No dependencies.
package swmrm_pkg;

  localparam int WINDOW      = 60;
  localparam int FILL_W      = $clog2(WINDOW + 1);
  localparam int STAMP_W     = 32;
  localparam int INTERVAL_W  = 16;
  localparam int FRAMES_W    = 16;
  localparam int RATE_W      = 24;
  localparam int OUT_FILL_W  = 6;
  localparam int SCALE_W     = 18;
  localparam int DIVIDEND_W  = FRAMES_W + SCALE_W;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

  localparam logic [SCALE_W-1:0]    RATE_SCALE     = SCALE_W'(256000);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);
  localparam logic [FRAMES_W-1:0]   FRAMES_MAX     = '1;
  localparam logic [RATE_W-1:0]     RATE_MAX       = '1;

  // Broadcast to every cell of the window chain.
  typedef struct packed {
    logic              del;   // drop one entry equal to key from the sorted row
    logic              ins;   // insert key into the sorted row, push key into the age row
    logic [RATE_W-1:0] key;
  } swmrm_cmd_t;

endpackage

[hdl/swmrm_cell.sv]
// swmrm_cell: one position of the window chain. Holds one sorted rate and one
// rate in arrival order, and trades them with its neighbors.
// Depends on swmrm_pkg.
module swmrm_cell
  import swmrm_pkg::*;
(
  input  logic              clk,
  input  swmrm_cmd_t        cmd,
  input  logic              occ,          // this position holds a sorted entry
  input  logic              left_occ,
  input  logic [RATE_W-1:0] left_val,
  input  logic [RATE_W-1:0] right_val,
  input  logic [RATE_W-1:0] right_age_val,
  output logic [RATE_W-1:0] val,
  output logic [RATE_W-1:0] age_val
);

  logic [RATE_W-1:0] val_r;
  logic [RATE_W-1:0] age_val_r;
  logic              gt_own;
  logic              gt_left;
  logic              ge_own;

  // empty positions count as larger than any key
  assign gt_own  = !occ || (val_r > cmd.key);
  assign ge_own  = !occ || (val_r >= cmd.key);
  assign gt_left = !left_occ || (left_val > cmd.key);

  always_ff @(posedge clk) begin
    if (cmd.del) begin
      if (ge_own) begin
        val_r <= right_val;
      end
    end else if (cmd.ins) begin
      if (gt_own) begin
        val_r <= gt_left ? left_val : cmd.key;
      end
    end
    if (cmd.ins) begin
      age_val_r <= right_age_val;
    end
  end

  assign val     = val_r;
  assign age_val = age_val_r;

endmodule

[hdl/swmrm_divider.sv]
// swmrm_divider: restoring divider, one quotient bit per cycle.
// Depends on swmrm_pkg.
module swmrm_divider
  import swmrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [STAMP_W-1:0]    divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIVIDEND_W-1:0] q_r;
  logic [STAMP_W-1:0]    rem_r;
  logic [STAMP_W-1:0]    div_r;
  logic [STAMP_W:0]      rem_sh;
  logic                  fits;

  assign rem_sh = {rem_r, q_r[DIVIDEND_W-1]};
  assign fits   = rem_sh >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIVIDEND_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? STAMP_W'(rem_sh - {1'b0, div_r}) : rem_sh[STAMP_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[hdl/sliding_window_median_rate_meter_unit.sv]
// Top level of the sliding window median frame rate meter.
// Depends on swmrm_pkg, swmrm_cell and swmrm_divider.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------
//   input   | in_frame_time_stamp                     | in_valid / in_ready
//   result  | out_frame_duration_ms, out_sample_taken,| out_valid / out_ready
//           | out_median_rate, out_window_fill        |
//   config  | cfg_wdata                               | cfg_we, no wait
//
// One item at a time. A frame that closes no interval goes from idle straight to the
// output load step; no new item is taken until the last one has been loaded out.
// A frame that closes an interval passes through these steps in order: multiply,
// divider start, the divider's 34-bit quotient bit by bit plus done, delete (full window
// only), insert, median select, output load; the next item is taken only after the load.
// A result waits in the output register while the next item is taken in; the block
// stalls at the end of an item only if the previous result is still untaken.
// rst_n is synchronous; after reset the window is empty and the interval is 1000 ms.
module sliding_window_median_rate_meter_unit
  import swmrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [STAMP_W-1:0]    in_frame_time_stamp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STAMP_W-1:0]    out_frame_duration_ms,
  output logic                  out_sample_taken,
  output logic [RATE_W-1:0]     out_median_rate,
  output logic [OUT_FILL_W-1:0] out_window_fill,
  input  logic                  cfg_we,
  input  logic [INTERVAL_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_DEL    = 3'd4;
  localparam logic [2:0] ST_INS    = 3'd5;
  localparam logic [2:0] ST_MED    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]              state_r;
  logic [2:0]              state_nxt;
  logic [INTERVAL_W-1:0]   interval_r;
  logic [STAMP_W-1:0]      prev_stamp_r;
  logic [STAMP_W-1:0]      start_stamp_r;
  logic [FRAMES_W-1:0]     frames_r;
  logic [FILL_W-1:0]       fill_r;
  logic [RATE_W-1:0]       median_r;
  logic [RATE_W-1:0]       rate_r;
  logic [DIVIDEND_W-1:0]   product_r;
  logic [STAMP_W-1:0]      elapsed_r;
  logic [FRAMES_W-1:0]     sample_frames_r;
  logic [STAMP_W-1:0]      duration_r;
  logic                    taken_r;
  logic                    out_valid_r;
  logic [STAMP_W-1:0]      out_duration_r;
  logic                    out_taken_r;
  logic [RATE_W-1:0]       out_median_r;
  logic [FILL_W-1:0]       out_fill_r;

  logic                    in_xfer;
  logic                    out_free;
  logic [INTERVAL_W-1:0]   interval_eff;
  logic [STAMP_W-1:0]      elapsed;
  logic [FRAMES_W-1:0]     frames_inc;
  logic                    close_interval;
  logic                    div_start;
  logic                    div_done;
  logic [DIVIDEND_W-1:0]   div_quot;
  logic [RATE_W-1:0]       rate_sat;
  logic [FILL_W-1:0]       med_idx;
  logic [RATE_W-1:0]       med_sel;
  swmrm_cmd_t              cmd;

  logic [RATE_W-1:0]       cell_val     [WINDOW];
  logic [RATE_W-1:0]       cell_age_val [WINDOW];
  logic [WINDOW-1:0]       occ;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign interval_eff   = (interval_r == '0) ? INTERVAL_W'(1) : interval_r;
  assign elapsed        = in_frame_time_stamp - start_stamp_r;
  assign frames_inc     = (frames_r == FRAMES_MAX) ? frames_r : frames_r + 1'b1;
  assign close_interval = elapsed >= {{(STAMP_W-INTERVAL_W){1'b0}}, interval_eff};
  assign rate_sat       = (div_quot[DIVIDEND_W-1:RATE_W] != '0) ? RATE_MAX
                                                                : div_quot[RATE_W-1:0];
  assign div_start      = (state_r == ST_DSTART);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = close_interval ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = (fill_r == FILL_W'(WINDOW)) ? ST_DEL : ST_INS;
        end
      end
      ST_DEL:    state_nxt = ST_INS;
      ST_INS:    state_nxt = ST_MED;
      ST_MED:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      interval_r    <= INTERVAL_RESET;
      prev_stamp_r  <= '0;
      start_stamp_r <= '0;
      frames_r      <= '0;
      fill_r        <= '0;
      median_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      if (in_xfer) begin
        prev_stamp_r <= in_frame_time_stamp;
        if (close_interval) begin
          frames_r      <= '0;
          start_stamp_r <= in_frame_time_stamp;
        end else begin
          frames_r <= frames_inc;
        end
      end
      if (state_r == ST_DEL) begin
        fill_r <= fill_r - 1'b1;
      end else if (state_r == ST_INS) begin
        fill_r <= fill_r + 1'b1;
      end
      if (state_r == ST_MED) begin
        median_r <= med_sel;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      duration_r      <= in_frame_time_stamp - prev_stamp_r;
      taken_r         <= close_interval;
      elapsed_r       <= elapsed;
      sample_frames_r <= frames_inc;
    end
    if (state_r == ST_MUL) begin
      product_r <= DIVIDEND_W'(sample_frames_r) * DIVIDEND_W'(RATE_SCALE);
    end
    if (state_r == ST_DIV && div_done) begin
      rate_r <= rate_sat;
    end
    if (state_r == ST_DONE && out_free) begin
      out_duration_r <= duration_r;
      out_taken_r    <= taken_r;
      out_median_r   <= median_r;
      out_fill_r     <= fill_r;
    end
  end

  swmrm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product_r),
    .divisor  (elapsed_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Deletion removes the oldest sample, which sits at the head of the age row
  // once the window is full.
  always_comb begin
    cmd.del = (state_r == ST_DEL);
    cmd.ins = (state_r == ST_INS);
    cmd.key = (state_r == ST_DEL) ? cell_age_val[0] : rate_r;
  end

  // Sorted entries always fill a prefix of the chain.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      occ[i] = FILL_W'(i) < fill_r;
    end
  end

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    logic              l_occ;
    logic [RATE_W-1:0] l_val;
    logic [RATE_W-1:0] r_val;
    logic [RATE_W-1:0] r_age;
    if (g == 0) begin : g_head
      assign l_occ = 1'b1;
      assign l_val = '0;
    end else begin : g_mid
      assign l_occ = occ[g-1];
      assign l_val = cell_val[g-1];
    end
    if (g == WINDOW - 1) begin : g_tail
      assign r_val = '0;
      assign r_age = rate_r;
    end else begin : g_body
      assign r_val = cell_val[g+1];
      assign r_age = cell_age_val[g+1];
    end
    swmrm_cell u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .occ           (occ[g]),
      .left_occ      (l_occ),
      .left_val      (l_val),
      .right_val     (r_val),
      .right_age_val (r_age),
      .val           (cell_val[g]),
      .age_val       (cell_age_val[g])
    );
  end

  // upper median: sorted entry at fill/2, zero when empty
  assign med_idx = fill_r >> 1;
  always_comb begin
    med_sel = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (occ[i] && (FILL_W'(i) == med_idx)) begin
        med_sel = med_sel | cell_val[i];
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_frame_duration_ms = out_duration_r;
  assign out_sample_taken      = out_taken_r;
  assign out_median_rate       = out_median_r;
  assign out_window_fill       = OUT_FILL_W'(out_fill_r);

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("window fill above capacity");

  a_del_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEL) |-> (fill_r == FILL_W'(WINDOW)))
    else $error("delete step with window not full");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("second transfer taken while item in flight");

  a_taken_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sample_taken) |-> (out_window_fill != '0))
    else $error("sample taken but window empty");

endmodule

[test/testbench.sv]
// Testbench for sliding_window_median_rate_meter_unit: frame stamps in, per-frame results
// checked against a scoreboard that tracks the interval, rate window and median itself.
// Depends on swmrm_pkg and the RTL of the rate meter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swmrm_pkg::*;

  typedef struct packed {
    logic [STAMP_W-1:0]    duration_ms;
    logic                  taken;
    logic [RATE_W-1:0]     median;
    logic [OUT_FILL_W-1:0] fill;
  } frame_result_t;

  class median_rate_scoreboard;
    logic [INTERVAL_W-1:0] interval_ms = INTERVAL_RESET;
    logic [STAMP_W-1:0]    prev_stamp = '0;
    logic [STAMP_W-1:0]    interval_start = '0;
    logic [FRAMES_W-1:0]   frames = '0;
    logic [RATE_W-1:0]     rates[$];
    frame_result_t         expected_results[$];
    int unsigned           mismatches = 0;

    function void note_frame(logic [STAMP_W-1:0] stamp);
      logic [STAMP_W-1:0] elapsed;
      logic [STAMP_W-1:0] period;
      logic [63:0]        rate;
      logic [RATE_W-1:0]  sorted[$];
      frame_result_t      res;
      res.duration_ms = stamp - prev_stamp;
      res.taken = 1'b0;
      prev_stamp = stamp;
      if (frames != FRAMES_MAX) frames++;
      // a zero interval behaves as one millisecond
      period = (interval_ms == '0) ? STAMP_W'(1) : STAMP_W'(interval_ms);
      elapsed = stamp - interval_start;
      if (elapsed >= period) begin
        rate = {48'd0, frames} * 64'd256000 / {32'd0, elapsed};
        if (rate > RATE_MAX) rate = RATE_MAX;
        if (rates.size() == WINDOW) void'(rates.pop_front());
        rates.push_back(rate[RATE_W-1:0]);
        frames = '0;
        interval_start = stamp;
        res.taken = 1'b1;
      end
      sorted = rates;
      sorted.sort();
      res.median = (sorted.size() == 0) ? '0 : sorted[sorted.size() / 2];
      res.fill = OUT_FILL_W'(rates.size());
      expected_results.push_back(res);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame result: dur=%0d taken=%0d median=%0d fill=%0d",
                   got.duration_ms, got.taken, got.median, got.fill);
        return;
      end
      want = expected_results.pop_front();
      if (got.duration_ms !== want.duration_ms || got.taken !== want.taken ||
          got.median !== want.median || got.fill !== want.fill) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("frame result mismatch at %0t: expected dur=%0d taken=%0d median=%0d fill=%0d",
                   $realtime, want.duration_ms, want.taken, want.median, want.fill);
          $display("  got dur=%0d taken=%0d median=%0d fill=%0d",
                   got.duration_ms, got.taken, got.median, got.fill);
        end
      end
    endfunction

    function int unsigned pending_count();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [STAMP_W-1:0]    in_frame_time_stamp = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STAMP_W-1:0]    out_frame_duration_ms;
  logic                  out_sample_taken;
  logic [RATE_W-1:0]     out_median_rate;
  logic [OUT_FILL_W-1:0] out_window_fill;
  logic                  cfg_we = 1'b0;
  logic [INTERVAL_W-1:0] cfg_wdata = '0;

  int unsigned           tx_idle_pct = 0;
  int unsigned           rx_stall_pct = 0;
  logic [STAMP_W-1:0]    last_stamp = '0;
  median_rate_scoreboard sb = new();

  sliding_window_median_rate_meter_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_frame_time_stamp   (in_frame_time_stamp),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_frame_duration_ms (out_frame_duration_ms),
    .out_sample_taken      (out_sample_taken),
    .out_median_rate       (out_median_rate),
    .out_window_fill       (out_window_fill),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // both channels sampled at the edge, input transfer noted before result check
  always @(posedge clk) begin : monitor
    frame_result_t got;
    if (rst_n && in_valid && in_ready) sb.note_frame(in_frame_time_stamp);
    if (rst_n && out_valid && out_ready) begin
      got.duration_ms = out_frame_duration_ms;
      got.taken = out_sample_taken;
      got.median = out_median_rate;
      got.fill = out_window_fill;
      sb.check_result(got);
    end
  end

  task automatic send_frame(input logic [STAMP_W-1:0] stamp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_time_stamp <= stamp;
    last_stamp = stamp;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_frames(input logic [STAMP_W-1:0] stamp, input int unsigned count);
    repeat (count) send_frame(stamp);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] value);
    wait_results_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    sb.interval_ms = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly forward steps that close an interval every few frames, plus
  // repeated stamps, backward steps and jumps anywhere on the clock
  task automatic send_random_frames(input int unsigned count);
    int unsigned        step_cap;
    logic [STAMP_W-1:0] stamp;
    step_cap = ((sb.interval_ms == '0) ? 1 : sb.interval_ms) / 3 + 1;
    repeat (count) begin
      case ($urandom_range(0, 15))
        0:       stamp = $urandom();
        1, 2:    stamp = last_stamp;
        3:       stamp = last_stamp - $urandom_range(1, step_cap);
        4:       stamp = last_stamp + step_cap * $urandom_range(3, 40);
        default: stamp = last_stamp + $urandom_range(0, step_cap);
      endcase
      send_frame(stamp);
    end
  endtask

  initial begin
    logic [STAMP_W-1:0]    opening[10];
    logic [STAMP_W-1:0]    base;
    logic [INTERVAL_W-1:0] settings[9];
    opening = '{32'd0, 32'd0, 32'd999, 32'd1000, 32'd1000, 32'hFFFF_FFFF, 32'd0,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678};
    settings = '{16'd1, 16'd40, 16'hFFFF, 16'd0, 16'd7, 16'd1000, 16'd2, 16'd300, 16'd12};
    settings[7] = INTERVAL_W'($urandom_range(1, 65535));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset interval, clock wrap and empty window
    foreach (opening[k]) send_frame(opening[k]);

    // rate saturation: many frames at one stamp, then one millisecond later
    base = 32'h1234_5678;
    write_interval(16'd1);
    send_frames(base, 70);
    send_frame(base + 1);

    // zero interval acts as one
    write_interval(16'd0);
    send_frames(base + 1, 3);
    send_frames(base + 2, 2);

    // longest interval: a burst at one stamp, then full-interval steps
    write_interval(16'hFFFF);
    send_frames(base + 2, 40);
    send_frame(base + 2 + 65535);
    send_frame(base + 2 + 2 * 65535);

    for (int g = 0; g < 3; g++) begin
      case (g)
        0:       begin tx_idle_pct = 12; rx_stall_pct = 86; end
        1:       begin tx_idle_pct = 86; rx_stall_pct = 12; end
        default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      for (int p = 0; p < 3; p++) begin
        write_interval(settings[g * 3 + p]);
        send_random_frames(136);
      end
    end

    wait_results_drained();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
hdl/swmrm_pkg.sv
hdl/swmrm_cell.sv
hdl/swmrm_divider.sv
hdl/sliding_window_median_rate_meter_unit.sv
test/testbench.sv
